@@ hdl/ptc_pkg.sv @@
package ptc_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // angle in degrees with 32 fraction bits, wide enough for the cordic residue
  localparam int ANGLE_W    = 42;
  localparam int ROT_XW     = 44;
  localparam int GUARD      = 8;
  localparam int ROT_VW     = ROT_XW - GUARD;
  localparam int GAIN_SHIFT = 29 - GUARD;
  localparam logic signed [29:0] GAIN_Q29 = 30'sd326016437;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_ROTATE    = 2'd1;
  localparam logic [1:0] OP_ENLARGE   = 2'd2;
  localparam logic [1:0] OP_SHRINK    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  center_x;
    logic signed [31:0]  center_y;
    logic signed [31:0]  amount_a;
    logic signed [31:0]  amount_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  new_x;
    logic signed [31:0]  new_y;
    logic [1:0]          status;
  } out_item_t;

  // conditional subtract steps that bring a 32-bit value below 360 degrees
  function automatic int red_steps(input int frac_bits);
    return 34 - $clog2(64'd360 << frac_bits);
  endfunction

  function automatic int rot_lat(input int frac_bits, input int steps);
    return red_steps(frac_bits) + steps + 4;
  endfunction

  function automatic int div_lat(input int frac_bits);
    return frac_bits + 35;
  endfunction

  // atan(2^-i) in degrees, 32 fraction bits
  function automatic logic [ANGLE_W-1:0] atan_deg(input int idx);
    case (idx)
      0:  return 42'd193273528320;
      1:  return 42'd114096026022;
      2:  return 42'd60285206653;
      3:  return 42'd30601712202;
      4:  return 42'd15360239180;
      5:  return 42'd7687607525;
      6:  return 42'd3844741810;
      7:  return 42'd1922488225;
      8:  return 42'd961258780;
      9:  return 42'd480631223;
      10: return 42'd240315841;
      11: return 42'd120157949;
      12: return 42'd60078978;
      13: return 42'd30039490;
      14: return 42'd15019745;
      15: return 42'd7509872;
      16: return 42'd3754936;
      17: return 42'd1877468;
      18: return 42'd938734;
      19: return 42'd469367;
      20: return 42'd234684;
      21: return 42'd117342;
      22: return 42'd58671;
      23: return 42'd29335;
      24: return 42'd14668;
      25: return 42'd7334;
      26: return 42'd3667;
      27: return 42'd1833;
      28: return 42'd917;
      29: return 42'd458;
      default: return '0;
    endcase
  endfunction

endpackage

@@ hdl/point_transform_about_center.sv @@
// Point transform about a centre: translate, rotate, enlarge or shrink one
// Q16.16 point per item.
// Input: an item is taken on each rising edge with start high and busy low.
// busy never rises, so a new item can be started in every cycle.
// Output: out_valid is high for one cycle with out_item holding new_x, new_y
// and status; there is no back pressure, the receiver must take it then.
// LAT_CORE is one more than the longest unit: the shrink divider, one
// quotient bit per bit stage, or the rotate path through the angle reduction
// steps and the CORDIC_STEPS iterations.
// Throughput is one item per cycle in steady state.
// Every path runs in lockstep and the valid bit travels beside the data, so
// results leave in the order items came in.
// Reset clears the valid pipe; items in flight at reset are dropped and no
// result appears until a new item is started.
module point_transform_about_center #(
  parameter int FRAC_BITS    = ptc_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ptc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ptc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ptc_pkg::out_item_t out_item
);

  localparam int QW       = FRAC_BITS + 33;
  localparam int DQW      = QW + 1;
  localparam int EW       = 65 - FRAC_BITS;
  localparam int VW       = ptc_pkg::ROT_VW;
  localparam int ROT_LAT  = ptc_pkg::rot_lat(FRAC_BITS, CORDIC_STEPS);
  localparam int DIV_LAT  = ptc_pkg::div_lat(FRAC_BITS);
  localparam int ENL_LAT  = 2;
  localparam int LAT_A    = ROT_LAT > DIV_LAT ? ROT_LAT : DIV_LAT;
  localparam int LAT_CORE = (LAT_A > ENL_LAT ? LAT_A : ENL_LAT) + 1;
  localparam int PAD_ROT  = LAT_CORE - ROT_LAT;
  localparam int PAD_DIV  = LAT_CORE - DIV_LAT;
  localparam int PAD_ENL  = LAT_CORE - ENL_LAT;
  localparam int OW       = EW > DQW ? EW : DQW;
  localparam logic signed [64:0] ROUND_E = 65'(1) << (FRAC_BITS - 1);
  localparam logic signed [OW:0] MAXV    = (OW+1)'(32'sh7fffffff);
  localparam logic signed [OW:0] MINV    = (OW+1)'(32'sh80000000);

  // input register
  logic              in_acc;
  logic              v0_r;
  ptc_pkg::in_item_t it0_r;
  logic signed [32:0] dx0_c;
  logic signed [32:0] dy0_c;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      it0_r <= in_item;
    end
  end

  assign dx0_c = 33'(it0_r.point_x) - 33'(it0_r.center_x);
  assign dy0_c = 33'(it0_r.point_y) - 33'(it0_r.center_y);

  // enlarge: split the scale into two halves, then sum and round
  logic signed [48:0]   pxh_r;
  logic signed [48:0]   pyh_r;
  logic signed [49:0]   pxl_r;
  logic signed [49:0]   pyl_r;
  logic signed [64:0]   prx_c;
  logic signed [64:0]   pry_c;
  logic signed [EW-1:0] ex_r;
  logic signed [EW-1:0] ey_r;

  always_ff @(posedge clk) begin
    pxh_r <= dx0_c * $signed(it0_r.amount_a[31:16]);
    pyh_r <= dy0_c * $signed(it0_r.amount_a[31:16]);
    pxl_r <= dx0_c * $signed({1'b0, it0_r.amount_a[15:0]});
    pyl_r <= dy0_c * $signed({1'b0, it0_r.amount_a[15:0]});
  end

  assign prx_c = (65'(pxh_r) <<< 16) + 65'(pxl_r) + ROUND_E;
  assign pry_c = (65'(pyh_r) <<< 16) + 65'(pyl_r) + ROUND_E;

  always_ff @(posedge clk) begin
    ex_r <= prx_c[64:FRAC_BITS];
    ey_r <= pry_c[64:FRAC_BITS];
  end

  // rotate and shrink units
  logic signed [VW-1:0]  rot_x;
  logic signed [VW-1:0]  rot_y;
  logic signed [DQW-1:0] quo_x;
  logic signed [DQW-1:0] quo_y;

  ptc_rotate #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_rotate (
    .clk   (clk),
    .angle (it0_r.amount_a),
    .vec_x (dx0_c),
    .vec_y (dy0_c),
    .rot_x (rot_x),
    .rot_y (rot_y)
  );

  ptc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk (clk),
    .num ($signed({dx0_c, {FRAC_BITS{1'b0}}})),
    .den (it0_r.amount_a),
    .quo (quo_x)
  );

  ptc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk (clk),
    .num ($signed({dy0_c, {FRAC_BITS{1'b0}}})),
    .den (it0_r.amount_a),
    .quo (quo_y)
  );

  // align every path to LAT_CORE
  logic [2*VW-1:0]   rot_pad_r [PAD_ROT];
  logic [2*DQW-1:0]  div_pad_r [PAD_DIV];
  logic [2*EW-1:0]   enl_pad_r [PAD_ENL];
  ptc_pkg::in_item_t ctx_r     [LAT_CORE];
  logic [LAT_CORE-1:0] vld_r;

  always_ff @(posedge clk) begin
    rot_pad_r[0] <= {rot_x, rot_y};
    for (int k = 1; k < PAD_ROT; k++) begin
      rot_pad_r[k] <= rot_pad_r[k-1];
    end
    div_pad_r[0] <= {quo_x, quo_y};
    for (int k = 1; k < PAD_DIV; k++) begin
      div_pad_r[k] <= div_pad_r[k-1];
    end
    enl_pad_r[0] <= {ex_r, ey_r};
    for (int k = 1; k < PAD_ENL; k++) begin
      enl_pad_r[k] <= enl_pad_r[k-1];
    end
    ctx_r[0] <= it0_r;
    for (int k = 1; k < LAT_CORE; k++) begin
      ctx_r[k] <= ctx_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT_CORE-2:0], v0_r};
    end
  end

  // select, add base, saturate
  ptc_pkg::in_item_t     ctx;
  logic                  fv;
  logic signed [VW-1:0]  rvx;
  logic signed [VW-1:0]  rvy;
  logic signed [DQW-1:0] dvx;
  logic signed [DQW-1:0] dvy;
  logic signed [EW-1:0]  evx;
  logic signed [EW-1:0]  evy;
  logic signed [31:0]    bx;
  logic signed [31:0]    by;
  logic signed [OW-1:0]  ox;
  logic signed [OW-1:0]  oy;
  logic signed [OW:0]    sx_c;
  logic signed [OW:0]    sy_c;
  logic signed [31:0]    nx_c;
  logic signed [31:0]    ny_c;
  logic                  satx_c;
  logic                  saty_c;
  logic                  divz_c;
  ptc_pkg::out_item_t    res_c;

  assign ctx = ctx_r[LAT_CORE-1];
  assign fv  = vld_r[LAT_CORE-1];
  assign {rvx, rvy} = rot_pad_r[PAD_ROT-1];
  assign {dvx, dvy} = div_pad_r[PAD_DIV-1];
  assign {evx, evy} = enl_pad_r[PAD_ENL-1];

  always_comb begin
    case (ctx.opcode)
      ptc_pkg::OP_TRANSLATE: begin
        bx = ctx.point_x;
        by = ctx.point_y;
        ox = OW'(ctx.amount_a);
        oy = OW'(ctx.amount_b);
      end
      ptc_pkg::OP_ROTATE: begin
        bx = ctx.center_x;
        by = ctx.center_y;
        ox = OW'(rvx);
        oy = OW'(rvy);
      end
      ptc_pkg::OP_ENLARGE: begin
        bx = ctx.center_x;
        by = ctx.center_y;
        ox = OW'(evx);
        oy = OW'(evy);
      end
      default: begin
        bx = ctx.center_x;
        by = ctx.center_y;
        ox = OW'(dvx);
        oy = OW'(dvy);
      end
    endcase
  end

  assign sx_c = (OW+1)'(bx) + (OW+1)'(ox);
  assign sy_c = (OW+1)'(by) + (OW+1)'(oy);

  always_comb begin
    satx_c = 1'b0;
    if (sx_c > MAXV) begin
      nx_c   = 32'sh7fffffff;
      satx_c = 1'b1;
    end else if (sx_c < MINV) begin
      nx_c   = 32'sh80000000;
      satx_c = 1'b1;
    end else begin
      nx_c = sx_c[31:0];
    end
    saty_c = 1'b0;
    if (sy_c > MAXV) begin
      ny_c   = 32'sh7fffffff;
      saty_c = 1'b1;
    end else if (sy_c < MINV) begin
      ny_c   = 32'sh80000000;
      saty_c = 1'b1;
    end else begin
      ny_c = sy_c[31:0];
    end
  end

  assign divz_c = (ctx.opcode == ptc_pkg::OP_SHRINK) && (ctx.amount_a == '0);

  always_comb begin
    if (divz_c) begin
      res_c.new_x  = ctx.point_x;
      res_c.new_y  = ctx.point_y;
      res_c.status = ptc_pkg::ST_DIV_ZERO;
    end else begin
      res_c.new_x  = nx_c;
      res_c.new_y  = ny_c;
      res_c.status = (satx_c || saty_c) ? ptc_pkg::ST_SAT : ptc_pkg::ST_OK;
    end
  end

  // output register
  logic               ov_r;
  ptc_pkg::out_item_t oitem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= fv;
    end
  end

  always_ff @(posedge clk) begin
    oitem_r <= res_c;
  end

  assign out_valid = ov_r;
  assign out_item  = oitem_r;

  // every started item strobes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(LAT_CORE + 2) out_valid)
    else $error("result strobe missing after fixed latency");

  // shrink by zero passes the point through with its own status
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fv && divz_c |=> out_valid && out_item.status == ptc_pkg::ST_DIV_ZERO &&
      out_item.new_x == $past(ctx.point_x) && out_item.new_y == $past(ctx.point_y))
    else $error("zero scale shrink not passed through");

  // a saturated result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ptc_pkg::ST_SAT |->
      out_item.new_x == 32'sh7fffffff || out_item.new_x == 32'sh80000000 ||
      out_item.new_y == 32'sh7fffffff || out_item.new_y == 32'sh80000000)
    else $error("saturation flagged without a clamped coordinate");

  // no strobe without an item at the end of the pipe
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !fv |=> !out_valid)
    else $error("result strobe without an item");

endmodule

@@ hdl/ptc_div.sv @@
module ptc_div #(
  parameter int FRAC_BITS = ptc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [FRAC_BITS+32:0] num,
  input  logic signed [31:0]           den,
  output logic signed [FRAC_BITS+33:0] quo
);

  localparam int QW = FRAC_BITS + 33;

  logic [QW-1:0] un_c;
  logic [31:0]   ud_c;
  logic [QW-1:0] n0_c;

  logic [QW-1:0] nq_r  [QW+1];
  logic [31:0]   rem_r [QW+1];
  logic [31:0]   ud_r  [QW+1];
  logic          neg_r [QW+1];
  logic signed [QW:0] quo_r;

  assign un_c = num[QW-1] ? $unsigned(-num) : $unsigned(num);
  assign ud_c = den[31] ? $unsigned(-den) : $unsigned(den);
  // half the divisor added up front gives round half away from zero
  assign n0_c = un_c + QW'(ud_c >> 1);

  always_ff @(posedge clk) begin
    nq_r[0]  <= n0_c;
    rem_r[0] <= '0;
    ud_r[0]  <= ud_c;
    neg_r[0] <= num[QW-1] ^ den[31];
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    assign trial = {rem_r[j], nq_r[j][QW-1]};
    assign diff  = trial - {1'b0, ud_r[j]};
    assign ge    = trial >= {1'b0, ud_r[j]};
    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? diff[31:0] : trial[31:0];
      nq_r[j+1]  <= {nq_r[j][QW-2:0], ge};
      ud_r[j+1]  <= ud_r[j];
      neg_r[j+1] <= neg_r[j];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[QW] ? -$signed({1'b0, nq_r[QW]}) : $signed({1'b0, nq_r[QW]});
  end

  assign quo = quo_r;

endmodule

@@ hdl/ptc_rotate.sv @@
module ptc_rotate #(
  parameter int FRAC_BITS    = ptc_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ptc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic signed [31:0]                 angle,
  input  logic signed [32:0]                 vec_x,
  input  logic signed [32:0]                 vec_y,
  output logic signed [ptc_pkg::ROT_VW-1:0]  rot_x,
  output logic signed [ptc_pkg::ROT_VW-1:0]  rot_y
);

  localparam int NRED = ptc_pkg::red_steps(FRAC_BITS);
  localparam int KMAX = NRED - 1;
  localparam longint unsigned MODV = 64'd360 << FRAC_BITS;
  localparam int TW = 36;
  localparam int WW = FRAC_BITS + 10;
  localparam int ZW = ptc_pkg::ANGLE_W;
  localparam int XW = ptc_pkg::ROT_XW;
  localparam int GD = ptc_pkg::GUARD;
  localparam logic signed [TW-1:0] MOD_S  = TW'(MODV);
  localparam logic signed [TW-1:0] HALF_S = TW'(MODV >> 1);
  localparam logic signed [TW-1:0] OFS_S  = TW'((64'd1 << 31) % MODV);
  localparam logic signed [WW-1:0] HALF_W = WW'(MODV >> 1);
  localparam logic signed [WW-1:0] QRT_W  = WW'(MODV >> 2);

  // modulo reduction of the angle, offset to unsigned
  logic [31:0]        red_r [NRED];
  logic signed [32:0] rdx_r [NRED];
  logic signed [32:0] rdy_r [NRED];

  for (genvar k = 0; k < NRED; k++) begin : g_red
    localparam logic [33:0] MK = 34'(MODV << (KMAX - k));
    logic [31:0]        src;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    if (k == 0) begin : g_first
      assign src = {~angle[31], angle[30:0]};
      assign sx  = vec_x;
      assign sy  = vec_y;
    end else begin : g_next
      assign src = red_r[k-1];
      assign sx  = rdx_r[k-1];
      assign sy  = rdy_r[k-1];
    end
    always_ff @(posedge clk) begin
      if ({2'b00, src} >= MK) begin
        red_r[k] <= src - MK[31:0];
      end else begin
        red_r[k] <= src;
      end
      rdx_r[k] <= sx;
      rdy_r[k] <= sy;
    end
  end

  // undo the offset and centre into [-180, 180)
  logic signed [TW-1:0] t_c;
  logic signed [TW-1:0] w_c;
  logic signed [WW-1:0] w_r;
  logic signed [32:0]   wdx_r;
  logic signed [32:0]   wdy_r;

  assign t_c = $signed(TW'(red_r[NRED-1])) - OFS_S;

  always_comb begin
    if (t_c < -HALF_S) begin
      w_c = t_c + MOD_S;
    end else if (t_c >= HALF_S) begin
      w_c = t_c - MOD_S;
    end else begin
      w_c = t_c;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_c[WW-1:0];
    wdx_r <= rdx_r[NRED-1];
    wdy_r <= rdy_r[NRED-1];
  end

  // fold into +-90 degrees, turning the vector half round instead
  logic signed [WW-1:0] zq_c;
  logic                 flip_c;
  logic signed [WW-1:0] zq_r;
  logic signed [33:0]   qx_r;
  logic signed [33:0]   qy_r;

  always_comb begin
    if (w_r > QRT_W) begin
      zq_c   = w_r - HALF_W;
      flip_c = 1'b1;
    end else if (w_r < -QRT_W) begin
      zq_c   = w_r + HALF_W;
      flip_c = 1'b1;
    end else begin
      zq_c   = w_r;
      flip_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    zq_r <= zq_c;
    qx_r <= flip_c ? -34'(wdx_r) : 34'(wdx_r);
    qy_r <= flip_c ? -34'(wdy_r) : 34'(wdy_r);
  end

  // gain prescale and cordic iterations, one per stage
  logic signed [63:0]   mx_c;
  logic signed [63:0]   my_c;
  logic signed [XW-1:0] xs_r [CORDIC_STEPS+1];
  logic signed [XW-1:0] ys_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs_r [CORDIC_STEPS+1];

  assign mx_c = qx_r * ptc_pkg::GAIN_Q29;
  assign my_c = qy_r * ptc_pkg::GAIN_Q29;

  always_ff @(posedge clk) begin
    xs_r[0] <= XW'(mx_c >>> ptc_pkg::GAIN_SHIFT);
    ys_r[0] <= XW'(my_c >>> ptc_pkg::GAIN_SHIFT);
    zs_r[0] <= ZW'(zq_r) <<< (32 - FRAC_BITS);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = ptc_pkg::atan_deg(i);
    always_ff @(posedge clk) begin
      if (!zs_r[i][ZW-1]) begin
        xs_r[i+1] <= xs_r[i] - (ys_r[i] >>> i);
        ys_r[i+1] <= ys_r[i] + (xs_r[i] >>> i);
        zs_r[i+1] <= zs_r[i] - ATAN_I;
      end else begin
        xs_r[i+1] <= xs_r[i] + (ys_r[i] >>> i);
        ys_r[i+1] <= ys_r[i] - (xs_r[i] >>> i);
        zs_r[i+1] <= zs_r[i] + ATAN_I;
      end
    end
  end

  // drop the guard bits, rounding half up
  logic signed [XW-1:0]            rx_c;
  logic signed [XW-1:0]            ry_c;
  logic signed [ptc_pkg::ROT_VW-1:0] rotx_r;
  logic signed [ptc_pkg::ROT_VW-1:0] roty_r;

  assign rx_c = xs_r[CORDIC_STEPS] + XW'(1 << (GD - 1));
  assign ry_c = ys_r[CORDIC_STEPS] + XW'(1 << (GD - 1));

  always_ff @(posedge clk) begin
    rotx_r <= rx_c[XW-1:GD];
    roty_r <= ry_c[XW-1:GD];
  end

  assign rot_x = rotx_r;
  assign rot_y = roty_r;

endmodule

@@ tb/ptc_checker.sv @@
`timescale 1ns / 100ps

module ptc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ptc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  ptc_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 points_due
);

  localparam int FRAC   = 16;
  localparam int STEPS  = 16;
  localparam int GRD    = 8;
  localparam longint GAIN = 64'sd326016437;

  // atan(2^-i) in degrees, 32 fraction bits
  longint atan_q32 [0:29] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
    64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
    64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
    64'sd60078978, 64'sd30039490, 64'sd15019745, 64'sd7509872,
    64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
    64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335,
    64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
    64'sd917, 64'sd458};

  ptc_pkg::out_item_t moved_points [$];

  function automatic longint sat32(input longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // cordic in degrees about the origin, guard bits kept through the loop
  function automatic void turn_vector(input longint ang, inout longint vx, inout longint vy);
    longint full, half, quarter, z, x, y, xs, ys;
    full = 64'sd360 <<< 32;
    half = 64'sd180 <<< 32;
    quarter = 64'sd90 <<< 32;
    z = ang * (64'sd1 <<< (32 - FRAC));
    z = z % full;
    if (z >= half) z = z - full;
    else if (z < -half) z = z + full;
    if (z > quarter) begin
      z = z - half; vx = -vx; vy = -vy;
    end else if (z < -quarter) begin
      z = z + half; vx = -vx; vy = -vy;
    end
    x = (vx * GAIN) >>> (29 - GRD);
    y = (vy * GAIN) >>> (29 - GRD);
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_q32[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_q32[i];
      end
    end
    vx = (x + (64'sd1 <<< (GRD - 1))) >>> GRD;
    vy = (y + (64'sd1 <<< (GRD - 1))) >>> GRD;
  endfunction

  // nearest, ties away from zero
  function automatic longint quot_nearest(input longint num, input longint den);
    longint unsigned un, ud, q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un + (ud >> 1)) / ud;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic ptc_pkg::out_item_t transform_point(input ptc_pkg::in_item_t it);
    longint px, py, cx, cy, a, b, dx, dy, nx, ny;
    bit clipped;
    ptc_pkg::out_item_t r;
    px = it.point_x; py = it.point_y;
    cx = it.center_x; cy = it.center_y;
    a = it.amount_a; b = it.amount_b;
    dx = px - cx; dy = py - cy;
    clipped = 0;
    r.status = ptc_pkg::ST_OK;
    case (it.opcode)
      ptc_pkg::OP_TRANSLATE: begin
        nx = px + a; ny = py + b;
      end
      ptc_pkg::OP_ROTATE: begin
        turn_vector(a, dx, dy);
        nx = cx + dx; ny = cy + dy;
      end
      ptc_pkg::OP_ENLARGE: begin
        nx = cx + ((dx * a + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
        ny = cy + ((dy * a + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      end
      default: begin
        if (a == 0) begin
          nx = px; ny = py; r.status = ptc_pkg::ST_DIV_ZERO;
        end else begin
          nx = cx + quot_nearest(dx <<< FRAC, a);
          ny = cy + quot_nearest(dy <<< FRAC, a);
        end
      end
    endcase
    nx = sat32(nx, clipped);
    ny = sat32(ny, clipped);
    if (clipped) r.status = ptc_pkg::ST_SAT;
    r.new_x = nx[31:0];
    r.new_y = ny[31:0];
    return r;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    ptc_pkg::out_item_t want;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (out_valid) begin
        if (moved_points.size() == 0) begin
          $error("result with no item outstanding: x %0d y %0d status %0d",
                 out_item.new_x, out_item.new_y, out_item.status);
          errs = errs + 1;
        end else begin
          want = moved_points.pop_front();
          if (out_item.new_x !== want.new_x) begin
            $error("new_x expected %0d actual %0d", want.new_x, out_item.new_x);
            errs = errs + 1;
          end
          if (out_item.new_y !== want.new_y) begin
            $error("new_y expected %0d actual %0d", want.new_y, out_item.new_y);
            errs = errs + 1;
          end
          if (out_item.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_item.status);
            errs = errs + 1;
          end
        end
      end
      if (start && !busy) moved_points.push_back(transform_point(in_item));
    end
    fail_count <= fail_count + errs;
    points_due <= moved_points.size();
  end

endmodule

@@ tb/point_transform_about_center_tb.sv @@
`timescale 1ns / 100ps

module point_transform_about_center_tb;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 70;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  ptc_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  ptc_pkg::out_item_t out_item;
  int                 fail_count;
  int                 points_due;
  int                 cycles = 0;

  always #6 clk = ~clk;

  point_transform_about_center u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  ptc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .points_due(points_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'h00010000;
          default: return 32'hffffffff;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7: return $urandom_range(1, 3);
      8: return $urandom_range(4, 10);
      default: return $urandom_range(11, 40);
    endcase
  endfunction

  // item stays on the port until the edge that takes it
  task automatic send_point(input ptc_pkg::in_item_t it, input int gap);
    bit taken;
    @(negedge clk);
    start <= 1;
    in_item <= it;
    do begin
      taken = !busy;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end while (!taken);
    if (gap > 0) begin
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic ptc_pkg::in_item_t make_point(input logic [1:0] op,
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] cx,
      input logic [31:0] cy, input logic [31:0] a, input logic [31:0] b);
    ptc_pkg::in_item_t it;
    it.opcode = op; it.point_x = px; it.point_y = py;
    it.center_x = cx; it.center_y = cy; it.amount_a = a; it.amount_b = b;
    return it;
  endfunction

  initial begin
    ptc_pkg::in_item_t it;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_point(make_point(ptc_pkg::OP_TRANSLATE, 32'h00010000, 32'h00020000, 0, 0,
               32'h00008000, 32'hffff0000), 0);
    send_point(make_point(ptc_pkg::OP_TRANSLATE, 32'h7fffffff, 32'h80000000, 0, 0,
               32'h00000001, 32'hffffffff), 0);
    send_point(make_point(ptc_pkg::OP_TRANSLATE, 32'h80000000, 32'h7fffffff,
               32'hffffffff, 0, 32'h80000000, 32'h7fffffff), 1);
    // rotations: quarter turns, beyond 90, negative, wrap past 360
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h000a0000, 32'h00050000, 32'h00010000,
               32'h00010000, 32'h005a0000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h000a0000, 32'h00050000, 32'h00010000,
               32'h00010000, 32'h00b40000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h000a0000, 32'hfffb0000, 0, 0,
               32'hff790000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h00030000, 32'h00040000, 0, 0,
               32'h01f40000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h002d0000, 0), 2);
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h00030000, 32'h00040000, 0, 0,
               32'h7fffffff, 0), 0);
    send_point(make_point(ptc_pkg::OP_ROTATE, 32'h00030000, 32'h00040000, 0, 0,
               32'h80000000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ENLARGE, 32'h00050000, 32'hfffd0000, 32'h00010000,
               32'h00010000, 32'h00020000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ENLARGE, 32'h00000001, 32'h00000003, 0, 0,
               32'h00008000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ENLARGE, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h80000000, 0), 0);
    send_point(make_point(ptc_pkg::OP_ENLARGE, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 0), 3);
    send_point(make_point(ptc_pkg::OP_SHRINK, 32'h00060000, 32'h00090000, 0, 0,
               32'h00020000, 32'h12345678), 0);
    // division by zero keeps the point
    send_point(make_point(ptc_pkg::OP_SHRINK, 32'h12345678, 32'h87654321, 5, 7, 0, 1), 0);
    send_point(make_point(ptc_pkg::OP_SHRINK, 32'h00000003, 32'hfffffffd, 0, 0,
               32'h00020000, 0), 0);
    send_point(make_point(ptc_pkg::OP_SHRINK, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h00000001, 0), 0);
    send_point(make_point(ptc_pkg::OP_SHRINK, 32'h7fffffff, 32'h80000000, 0, 0,
               32'h80000000, 0), 0);
    send_point(make_point(ptc_pkg::OP_SHRINK, 32'h00050000, 32'h00050000, 0, 0,
               32'hfffe0000, 0), 5);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it.opcode   = 2'($urandom_range(0, 3));
      it.point_x  = pick_value();
      it.point_y  = pick_value();
      it.center_x = pick_value();
      it.center_y = pick_value();
      it.amount_a = pick_value();
      it.amount_b = pick_value();
      if (it.opcode == ptc_pkg::OP_ROTATE && $urandom_range(0, 1))
        it.amount_a = $signed($urandom_range(0, 32'h05a00000)) - 32'sh02d00000;
      if (it.opcode == ptc_pkg::OP_SHRINK && $urandom_range(0, 15) == 0)
        it.amount_a = 0;
      // long stretches with no gaps now and then
      send_point(it, ((n / 200) % 3 == 1) ? 0 : pick_gap());
    end
    @(negedge clk);
    start <= 0;

    wait (points_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && points_due == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
